// ----- hdl/sha256_pkg.sv -----
package sha256_pkg;

	localparam int BlockBytes = 64;
	localparam int Rounds     = 64;
	localparam int DigestWords = 8;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic       load_byte;
		logic       load_pad;
		logic       load_len;
		logic       comp_start;
		logic       comp_step;
		logic       comp_final;
		logic       hash_init;
		logic       add_block_len;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       round_last;
	} dp_stat_t;

	function automatic word_t round_k(input logic [5:0] i);
		word_t k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t init_hash(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- hdl/sha256_if.sv -----
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;
	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- hdl/sha256_datapath.sv -----
module sha256_datapath
	import sha256_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  logic [7:0] data_byte,
	input  logic [2:0] rd_index,
	output dp_stat_t   stat,
	output word_t      hash_word
);

	// block buffer held as 16 big-endian words, also used as the schedule window
	word_t       w_q [16];
	word_t       h_q [8];
	word_t       v_q [8];
	logic [5:0]  fill_q;
	logic [5:0]  round_q;
	logic [63:0] len_q;
	logic [63:0] total;
	word_t       wt, wnew, s0, s1, e1, ch, t1, e0, mj, kt;
	logic [3:0]  wi;
	logic [1:0]  bi;

	assign total = len_q + {55'd0, fill_q, 3'd0};
	assign wi = fill_q[5:2];
	assign bi = fill_q[1:0];
	assign kt = round_k(round_q);
	assign wt = w_q[0];
	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wnew = s1 + w_q[9] + s0 + w_q[0];
	assign e1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1 = v_q[7] + e1 + ch + kt + wt;
	assign e0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
	assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);

	assign stat.fill = fill_q;
	assign stat.round_last = (round_q == 6'(Rounds - 1));
	assign hash_word = h_q[rd_index];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			round_q <= '0;
			len_q   <= '0;
		end else begin
			if (cmd.hash_init) begin
				fill_q <= '0;
				len_q  <= '0;
			end else if (cmd.load_byte) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.add_block_len)
				len_q <= len_q + 64'd512;
			if (cmd.comp_start)
				round_q <= '0;
			else if (cmd.comp_step)
				round_q <= round_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			case (bi)
				2'd0: w_q[wi][31:24] <= data_byte;
				2'd1: w_q[wi][23:16] <= data_byte;
				2'd2: w_q[wi][15:8]  <= data_byte;
				default: w_q[wi][7:0] <= data_byte;
			endcase
		end
		if (cmd.load_pad) begin
			// 0x80 after the stored bytes, zeros to the end of the block
			for (int j = 0; j < 16; j++) begin
				if (j == int'(wi)) begin
					case (bi)
						2'd0: w_q[j] <= 32'h80000000;
						2'd1: w_q[j] <= {w_q[j][31:24], 24'h800000};
						2'd2: w_q[j] <= {w_q[j][31:16], 16'h8000};
						default: w_q[j] <= {w_q[j][31:8], 8'h80};
					endcase
				end else if (j > int'(wi)) begin
					w_q[j] <= '0;
				end
			end
		end
		if (cmd.load_len) begin
			// second pad block: all zeros but the length, unless pad fit already
			if (fill_q >= 6'd56)
				for (int j = 0; j < 14; j++)
					w_q[j] <= '0;
			w_q[14] <= total[63:32];
			w_q[15] <= total[31:0];
		end
		if (cmd.comp_step) begin
			for (int j = 0; j < 15; j++)
				w_q[j] <= w_q[j + 1];
			w_q[15] <= wnew;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++)
				h_q[j] <= init_hash(3'(j));
		end else if (cmd.hash_init) begin
			for (int j = 0; j < 8; j++)
				h_q[j] <= init_hash(3'(j));
		end else if (cmd.comp_final) begin
			for (int j = 0; j < 8; j++)
				h_q[j] <= h_q[j] + v_q[j];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.comp_start) begin
			for (int j = 0; j < 8; j++)
				v_q[j] <= h_q[j];
		end else if (cmd.comp_step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + e0 + mj;
		end
	end

endmodule

// ----- hdl/sha256_ctrl.sv -----
module sha256_ctrl
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sha256_in_if.sink   in_ch,
	input  dp_stat_t    stat,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [2:0]  rd_index,
	output dp_cmd_t     cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_ROUND = 3'd2;
	localparam logic [2:0] S_FINAL = 3'd3;
	localparam logic [2:0] S_PAD   = 3'd4;
	localparam logic [2:0] S_LEN   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	localparam logic [1:0] PH_DATA = 2'd0;
	localparam logic [1:0] PH_PAD  = 2'd1;
	localparam logic [1:0] PH_LEN  = 2'd2;

	logic [2:0] state_q, state_d;
	logic       eom_q, eom_d;   // message end pending after this compression
	logic [1:0] phase_q, phase_d; // data block, pad block or length block
	logic [2:0] idx_q, idx_d;
	logic       acc;

	assign in_ch.ready = (state_q == S_IDLE);
	assign acc = in_ch.valid && in_ch.ready;
	assign out_valid = (state_q == S_OUT);
	assign rd_index = idx_q;

	always_comb begin
		state_d = state_q;
		eom_d   = eom_q;
		phase_d = phase_q;
		idx_d   = idx_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd.load_byte = in_ch.byte_present;
					eom_d = in_ch.end_of_message;
					if (in_ch.byte_present && stat.fill == 6'd63) begin
						phase_d = PH_DATA;
						state_d = S_START;
					end else if (in_ch.end_of_message) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				cmd.load_pad = 1'b1;
				if (stat.fill >= 6'd56) begin
					phase_d = PH_PAD;
					state_d = S_START;
				end else begin
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				cmd.load_len = 1'b1;
				phase_d = PH_LEN;
				state_d = S_START;
			end
			S_START: begin
				cmd.comp_start = 1'b1;
				state_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.comp_step = 1'b1;
				if (stat.round_last)
					state_d = S_FINAL;
			end
			S_FINAL: begin
				cmd.comp_final = 1'b1;
				case (phase_q)
					PH_DATA: begin
						cmd.add_block_len = 1'b1;
						state_d = eom_q ? S_PAD : S_IDLE;
					end
					PH_PAD: state_d = S_LEN;
					default: begin
						idx_d = '0;
						state_d = S_OUT;
					end
				endcase
			end
			S_OUT: begin
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.hash_init = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eom_q   <= 1'b0;
			phase_q <= PH_DATA;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			eom_q   <= eom_d;
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

endmodule

// ----- hdl/sha256_stream_hasher_unit.sv -----
// sha-256 hasher over a byte stream
// in_ch: one item per cycle at most; an item may carry a byte (byte_present)
// and may close the message (end_of_message). in_ch.ready is high while the
// block waits for input.
// out_ch: eight digest words, word_index 0 first, last_word on the eighth.
// a byte that does not fill the block leaves it ready for the next item; the
// 64th byte starts a compression (load, 64 rounds, feed-forward) in the
// single shared round unit, and no input is taken until it ends. a closing
// item adds a pad step, a length step and one or two compressions before the
// first digest word appears.
// the words are held while out_ch.ready is low; no input is taken until the
// eighth word is taken, then the hash restarts for the next message.
// reset puts the initial hash values in place and clears byte and bit counts.
module sha256_stream_hasher_unit
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sha256_in_if.sink   in_ch,
	sha256_out_if.source out_ch
);

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [2:0] rd_index;

	sha256_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.stat      (stat),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.rd_index  (rd_index),
		.cmd       (cmd)
	);

	sha256_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (in_ch.data_byte),
		.rd_index  (rd_index),
		.stat      (stat),
		.hash_word (out_ch.digest_word)
	);

	assign out_ch.word_index = rd_index;
	assign out_ch.last_word  = (rd_index == 3'(DigestWords - 1));

endmodule
